>>> src/gaes_pkg.sv
// gaes_pkg: types, constants and helpers for the gae advantage scan
// used by every module of the block but gaes_ram; depends on nothing

package gaes_pkg;

  localparam int ENVS = 64;
  localparam int LANE_W = (ENVS > 1) ? $clog2(ENVS) : 1;
  localparam int ENV_W = 6;
  localparam int DATA_W = 32;
  localparam int COEF_W = 17;
  localparam int FRAC_W = 16;
  localparam int PROD_W = DATA_W + COEF_W + 1;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int DELTA_W = TERM_W + 1;
  localparam int SUM_W = DELTA_W + 1;
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  localparam logic [COEF_W-1:0] DISCOUNT_RST = 17'd64881;
  localparam logic [COEF_W-1:0] DISCOUNT_LAMBDA_RST = 17'd61637;

  // register index codes, taken from paddr[2]
  localparam logic REG_DISCOUNT = 1'b0;
  localparam logic REG_DISCOUNT_LAMBDA = 1'b1;

  typedef struct packed {
    logic [ENV_W-1:0]         env_index;
    logic                     rollout_start;
    logic signed [DATA_W-1:0] reward;
    logic signed [DATA_W-1:0] value_estimate;
    logic                     done_req;
  } in_item_t;

  typedef struct packed {
    logic [ENV_W-1:0]         env_out;
    logic signed [DATA_W-1:0] advantage;
    logic signed [DATA_W-1:0] target_return;
  } out_item_t;

  typedef struct packed {
    logic [ENV_W-1:0]         env;
    logic [LANE_W-1:0]        lane;
    logic                     zero_state;
    logic                     cut;
    logic signed [DATA_W-1:0] reward;
    logic signed [DATA_W-1:0] value;
  } step_t;

  typedef struct packed {
    logic [COEF_W-1:0] discount;
    logic [COEF_W-1:0] discount_lambda;
  } coef_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> src/gae_advantage_scan.sv
// gae_advantage_scan: top level, coefficient registers on the apb port
// depends on gaes_pkg, gaes_front, gaes_back (and gaes_ram below it)
//
//   port group   dir  transfer when             payload
//   in_*         in   in_valid && !in_stall     in_item_t (one rollout step)
//   out_*        out  out_valid && !out_stall   out_item_t (advantage, return)
//   apb          in   psel penable pwrite       discount at 0, discount_lambda at 4
//
// one step per cycle sustained while neither in_stall nor a full output queue holds
// it back; a step passes the input queue, stages b, c and d and the output queue before
// out_valid shows its result. the rate is set by the per-lane multiply, add and saturate
// of the running advantage, with forwarding from the two newest writes of a lane.
// reset clears queues and pipeline and reloads the coefficients; lane state is
// undefined until a step with rollout_start writes it. in_stall rises when the
// two-entry input queue is full; steps issue only while the eight-entry output
// queue has room for all steps in flight.

module gae_advantage_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gaes_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gaes_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gaes_pkg::ADDR_W-1:0]   paddr,
  input  logic [gaes_pkg::PDATA_W-1:0]  pwdata,
  output logic [gaes_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  gaes_pkg::coef_t coef;
  gaes_pkg::step_t head;
  logic            head_valid;
  logic            pop;
  logic            wr_access;

  assign pready = 1'b1;
  assign wr_access = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.discount <= gaes_pkg::DISCOUNT_RST;
      coef.discount_lambda <= gaes_pkg::DISCOUNT_LAMBDA_RST;
    end else if (wr_access) begin
      case (paddr[2])
        gaes_pkg::REG_DISCOUNT: begin
          coef.discount <= pwdata[gaes_pkg::COEF_W-1:0];
        end
        gaes_pkg::REG_DISCOUNT_LAMBDA: begin
          coef.discount_lambda <= pwdata[gaes_pkg::COEF_W-1:0];
        end
        default: begin
          coef <= coef;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gaes_pkg::REG_DISCOUNT: prdata = gaes_pkg::PDATA_W'(coef.discount);
      gaes_pkg::REG_DISCOUNT_LAMBDA: prdata = gaes_pkg::PDATA_W'(coef.discount_lambda);
      default: prdata = '0;
    endcase
  end

  gaes_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  gaes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> src/gaes_ram.sv
// gaes_ram: generic single-write, single-read ram with registered read data
// read-first on a same-address write; no dependencies

module gaes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/gaes_front.sv
// gaes_front: input acceptance, lane and flag decode, two-entry step queue
// depends on gaes_pkg

module gaes_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gaes_pkg::in_item_t in_data,
  output logic               head_valid,
  output gaes_pkg::step_t    head,
  input  logic               pop
);

  gaes_pkg::step_t queue [2];
  gaes_pkg::step_t decoded;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;

  always_comb begin
    decoded.env = in_data.env_index;
    decoded.lane = gaes_pkg::LANE_W'(in_data.env_index % gaes_pkg::ENVS);
    decoded.zero_state = in_data.rollout_start;
    decoded.cut = in_data.done_req;
    decoded.reward = in_data.reward;
    decoded.value = in_data.value_estimate;
  end

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign head = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/gaes_back.sv
// gaes_back: lane state rams, bootstrap and decay arithmetic with forwarding,
// return saturation and output queue; depends on gaes_pkg and gaes_ram

module gaes_back (
  input  logic                clk,
  input  logic                rst,
  input  gaes_pkg::coef_t     coef,
  input  logic                head_valid,
  input  gaes_pkg::step_t     head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output gaes_pkg::out_item_t out_data
);

  localparam int DW = gaes_pkg::DATA_W;
  localparam int LW = gaes_pkg::LANE_W;
  localparam int PW = gaes_pkg::PROD_W;
  localparam int TW = gaes_pkg::TERM_W;
  localparam int EW = gaes_pkg::DELTA_W;
  localparam int SW = gaes_pkg::SUM_W;
  localparam int FW = gaes_pkg::FRAC_W;
  localparam int QW = gaes_pkg::OUT_PTR_W;

  // stage b
  logic                   vb;
  gaes_pkg::step_t        sb;
  logic signed [DW-1:0]   lv_rd;
  logic signed [DW-1:0]   lv_b;
  logic signed [PW-1:0]   boot_prod;
  logic signed [TW-1:0]   boot;
  logic signed [EW-1:0]   delta_b;

  // stage c
  logic                   vc;
  gaes_pkg::step_t        sc;
  logic signed [EW-1:0]   delta_c;
  logic signed [DW-1:0]   ra_rd;
  logic signed [DW-1:0]   run_ram_c;
  logic signed [DW-1:0]   run_fwd;
  logic signed [DW-1:0]   run_c;
  logic signed [PW-1:0]   decay_prod;
  logic signed [TW-1:0]   decay;
  logic signed [SW-1:0]   adv_sum;
  logic signed [DW-1:0]   adv_c;

  // stage d and forward history
  logic                   vd;
  logic [LW-1:0]          lane_d;
  logic [gaes_pkg::ENV_W-1:0] env_d;
  logic signed [DW-1:0]   adv_d;
  logic signed [DW-1:0]   value_d;
  logic                   v2;
  logic [LW-1:0]          lane2;
  logic signed [DW-1:0]   adv2;
  logic signed [SW-1:0]   ret_sum;
  gaes_pkg::out_item_t    result_d;

  // output queue
  gaes_pkg::out_item_t    out_q [gaes_pkg::OUT_DEPTH];
  logic [QW-1:0]          out_wptr;
  logic [QW-1:0]          out_rptr;
  logic [QW:0]            out_count;
  logic [QW+1:0]          committed;
  logic                   out_pop;

  // issue only when the output queue can hold every step in flight
  assign committed = (QW+2)'(out_count) + (QW+2)'(vb) + (QW+2)'(vc) + (QW+2)'(vd);
  assign pop = head_valid && (committed < (QW+2)'(gaes_pkg::OUT_DEPTH));

  gaes_ram #(.WIDTH(DW), .DEPTH(gaes_pkg::ENVS)) u_later_value (
    .clk     (clk),
    .wr_en   (pop),
    .wr_addr (head.lane),
    .wr_data (head.value),
    .rd_addr (head.lane),
    .rd_data (lv_rd)
  );

  gaes_ram #(.WIDTH(DW), .DEPTH(gaes_pkg::ENVS)) u_running_adv (
    .clk     (clk),
    .wr_en   (vc),
    .wr_addr (sc.lane),
    .wr_data (adv_c),
    .rd_addr (head.lane),
    .rd_data (ra_rd)
  );

  // bootstrap term and delta
  always_comb begin
    lv_b = sb.zero_state ? '0 : lv_rd;
    boot_prod = lv_b * $signed({1'b0, coef.discount});
    boot = sb.cut ? '0 : boot_prod[PW-1:FW];
    delta_b = EW'(sb.reward) - EW'(sb.value) + EW'(boot);
  end

  // decay term, forwarded from the two newest writes of the same lane
  always_comb begin
    if (vd && (lane_d == sc.lane)) begin
      run_fwd = adv_d;
    end else if (v2 && (lane2 == sc.lane)) begin
      run_fwd = adv2;
    end else begin
      run_fwd = run_ram_c;
    end
    run_c = sc.zero_state ? '0 : run_fwd;
    decay_prod = run_c * $signed({1'b0, coef.discount_lambda});
    decay = sc.cut ? '0 : decay_prod[PW-1:FW];
    adv_sum = SW'(delta_c) + SW'(decay);
    adv_c = gaes_pkg::sat32(adv_sum);
  end

  always_comb begin
    ret_sum = SW'(adv_d) + SW'(value_d);
    result_d.env_out = env_d;
    result_d.advantage = adv_d;
    result_d.target_return = gaes_pkg::sat32(ret_sum);
  end

  always_ff @(posedge clk) begin
    sb <= head;
    sc <= sb;
    delta_c <= delta_b;
    run_ram_c <= ra_rd;
    lane_d <= sc.lane;
    env_d <= sc.env;
    adv_d <= adv_c;
    value_d <= sc.value;
    lane2 <= lane_d;
    adv2 <= adv_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      v2 <= 1'b0;
    end else begin
      vb <= pop;
      vc <= vb;
      vd <= vc;
      v2 <= vd;
    end
  end

  assign out_valid = (out_count != '0);
  assign out_data = out_q[out_rptr];
  assign out_pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (vd) begin
      out_q[out_wptr] <= result_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wptr <= '0;
      out_rptr <= '0;
      out_count <= '0;
    end else begin
      if (vd) begin
        out_wptr <= out_wptr + 1'b1;
      end
      if (out_pop) begin
        out_rptr <= out_rptr + 1'b1;
      end
      out_count <= out_count + (QW+1)'(vd) - (QW+1)'(out_pop);
    end
  end

endmodule
